// ===== hw/rtl/sqe_pkg.sv =====
// Shared constants, command/status types for the sample quantile engine.
`default_nettype none

package sqe_pkg;

  localparam int unsigned MaxSamples  = 1024;
  localparam int unsigned AddrW       = $clog2(MaxSamples);
  localparam int unsigned CntW        = AddrW + 1;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned FracW       = 16;
  localparam int unsigned ProbW       = 17;
  localparam int unsigned NumProbRegs = 6;
  localparam int unsigned NumProbW    = 3;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned ResultW     = 32;
  localparam int unsigned MulW        = ProbW + CntW;
  localparam int unsigned PosW        = MulW + 1;
  localparam int unsigned PosIntW     = PosW - 1 - FracW;

  localparam logic [ProbW-1:0]    ProbOne        = ProbW'(65536);
  localparam logic [PosW-1:0]     HalfQ16        = PosW'(32768);
  localparam logic [NumProbW-1:0] NumProbsReset  = NumProbW'(5);
  localparam logic [CfgIdxW-1:0]  CfgNumProbs    = CfgIdxW'(0);
  localparam logic [ProbW-1:0]    ProbReset [NumProbRegs] =
    '{ProbW'(0), ProbW'(1638), ProbW'(32768), ProbW'(63898), ProbW'(65536), ProbW'(32768)};

  typedef enum logic [2:0] {
    RD_I,
    RD_JM1,
    RD_JM2,
    RD_LO,
    RD_HI
  } rd_sel_e;

  typedef enum logic {
    WR_SHIFT,
    WR_PUT
  } wr_sel_e;

  typedef struct packed {
    logic    load_en;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    v_load;
    logic    j_load;
    logic    j_dec;
    logic    i_init;
    logic    i_inc;
    logic    k_init;
    logic    k_inc;
    logic    pos_load;
    logic    idx_load;
    logic    dl_load;
    logic    prod_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic ds_done;
    logic n_zero;
    logic n_gt1;
    logic i_next_lt_n;
    logic shift_gt;
    logic j_is_one;
    logic last_k;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sample_quantile_engine.sv =====
// Top level of the sample quantile engine (type 5, linear interpolation).
//
//  channel | signals                                         | dir
//  in      | in_valid_i/in_ready_o, sample_i, has_sample_i,  | in
//          | last_i                                          |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i| in
//  out     | out_valid_o/out_ready_i, quantile_value_o,      | out
//          | prob_index_o, last_result_o                     |
//
// Loading takes one beat per cycle, while in_ready_o is high, into a single-port-per-direction store.
// After the closing beat the set is insertion-sorted in place (read, compare
// and shift per element move, then put), O(n^2) overall, set by the store's
// single read port. Each quantile then steps through multiply, index, two
// reads, multiply, add. Input is held off until the last result of a dataset
// is in the output register; cfg is always ready. Reset is asynchronous,
// active low; no clearing pass is needed.
`default_nettype none

module sample_quantile_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sqe_pkg::SampleW-1:0]   sample_i,
  input  wire logic                          has_sample_i,
  input  wire logic                          last_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sqe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sqe_pkg::ProbW-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sqe_pkg::ResultW-1:0]        quantile_value_o,
  output logic [sqe_pkg::IdxW-1:0]           prob_index_o,
  output logic                               last_result_o
);
  import sqe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sqe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sqe_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .has_sample_i     (has_sample_i),
    .last_i           (last_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quantile_value_o (quantile_value_o),
    .prob_index_o     (prob_index_o),
    .last_result_o    (last_result_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sqe_ctrl.sv =====
// Sequencer: load, in-place insertion sort, per-probability interpolation.
`default_nettype none

module sqe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sqe_pkg::sts_t      sts_i,
  output sqe_pkg::cmd_t      cmd_o
);
  import sqe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD_I,
    ST_GET_V,
    ST_CMP,
    ST_PUT,
    ST_POS,
    ST_IDX,
    ST_RD_LO,
    ST_RD_HI,
    ST_MUL,
    ST_SUM
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_I;
    cmd_o.wr_sel = WR_PUT;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_en = 1'b1;
        if (sts_i.ds_done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.n_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.i_init = 1'b1;
          cmd_o.k_init = 1'b1;
          state_d = sts_i.n_gt1 ? ST_RD_I : ST_POS;
        end
      end
      ST_RD_I: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_I;
        cmd_o.j_load = 1'b1;
        state_d = ST_GET_V;
      end
      ST_GET_V: begin
        cmd_o.v_load = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_JM1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.shift_gt) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_SHIFT;
          cmd_o.j_dec  = 1'b1;
          if (sts_i.j_is_one) begin
            state_d = ST_PUT;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_JM2;
          end
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_PUT;
        cmd_o.i_inc  = 1'b1;
        state_d = sts_i.i_next_lt_n ? ST_RD_I : ST_POS;
      end
      ST_POS: begin
        cmd_o.pos_load = 1'b1;
        state_d = ST_IDX;
      end
      ST_IDX: begin
        cmd_o.idx_load = 1'b1;
        state_d = ST_RD_LO;
      end
      ST_RD_LO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LO;
        state_d = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd_o.dl_load = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_HI;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.prod_load = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.k_inc    = 1'b1;
          state_d = sts_i.last_k ? ST_IDLE : ST_POS;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy) else $error("result overwrite");
  // a dataset close returns to the check step
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && sts_i.ds_done) |=> state_q == ST_CHECK)
    else $error("close not followed by check");
  // sort writes never coincide with loading
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !cmd_o.load_en) else $error("write conflict");

endmodule

`default_nettype wire

// ===== hw/rtl/sqe_datapath.sv =====
// Sample store, config registers, sort indices and interpolation arithmetic.
`default_nettype none

module sqe_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [sqe_pkg::SampleW-1:0]   sample_i,
  input  wire logic                          has_sample_i,
  input  wire logic                          last_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [sqe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sqe_pkg::ProbW-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sqe_pkg::ResultW-1:0]        quantile_value_o,
  output logic [sqe_pkg::IdxW-1:0]           prob_index_o,
  output logic                               last_result_o,
  input  sqe_pkg::cmd_t                      cmd_i,
  output sqe_pkg::sts_t                      sts_o
);
  import sqe_pkg::*;

  logic [SampleW-1:0]  mem [MaxSamples];
  logic [SampleW-1:0]  rdata_q;
  logic [CntW-1:0]     cnt_q, n_q;
  logic [AddrW-1:0]    i_q, j_q, lo_q, hi_q;
  logic [SampleW-1:0]  v_q, dl_q;
  logic [IdxW-1:0]     k_q;
  logic [NumProbW-1:0] num_probs_q;
  logic [ProbW-1:0]    prob_q [NumProbRegs];
  logic [PosW-1:0]     pos_q;
  logic [FracW-1:0]    frac_q;
  logic [ResultW-1:0]  prod_q, out_q;
  logic [IdxW-1:0]     out_idx_q;
  logic                out_last_q, out_valid_q;

  logic                in_fire, ld_wr, room;
  logic [CntW-1:0]     cnt_inc, nm1;
  logic [AddrW-1:0]    raddr, waddr;
  logic [SampleW-1:0]  wdata;
  logic                wr;
  logic [ProbW-1:0]    p_sat;
  logic [MulW-1:0]     pn;
  logic [PosIntW-1:0]  lo_full, hi_full, nm1_ext;
  logic [FracW-1:0]    frac;
  logic [IdxW-1:0]     used_m1;

  assign in_ready_o = cmd_i.load_en;
  assign in_fire    = in_valid_i & in_ready_o;
  assign room       = (cnt_q < CntW'(MaxSamples));
  assign ld_wr      = in_fire & has_sample_i & room;
  assign cnt_inc    = cnt_q + CntW'(ld_wr);
  assign nm1        = n_q - CntW'(1);

  // store ports: load writes at the fill count, sort writes at j
  always_comb begin
    case (cmd_i.rd_sel)
      RD_I:    raddr = i_q;
      RD_JM1:  raddr = j_q - AddrW'(1);
      RD_JM2:  raddr = j_q - AddrW'(2);
      RD_LO:   raddr = lo_q;
      RD_HI:   raddr = hi_q;
      default: raddr = i_q;
    endcase
    wr    = ld_wr | cmd_i.wr_en;
    waddr = ld_wr ? cnt_q[AddrW-1:0] : j_q;
    wdata = ld_wr ? sample_i : ((cmd_i.wr_sel == WR_SHIFT) ? rdata_q : v_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[raddr];
  end

  // fill count and dataset size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q   <= '0;
    end else if (in_fire) begin
      if (last_i) begin
        n_q   <= cnt_inc;
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_inc;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_probs_q <= NumProbsReset;
      for (int r = 0; r < NumProbRegs; r++) prob_q[r] <= ProbReset[r];
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgNumProbs) begin
        num_probs_q <= cfg_data_i[NumProbW-1:0];
      end else if (cfg_index_i <= CfgIdxW'(NumProbRegs)) begin
        prob_q[cfg_index_i - CfgIdxW'(1)] <= cfg_data_i;
      end
    end
  end

  // sort indices and held value
  always_ff @(posedge clk_i) begin
    if (cmd_i.i_init)      i_q <= AddrW'(1);
    else if (cmd_i.i_inc)  i_q <= i_q + AddrW'(1);
    if (cmd_i.j_load)      j_q <= i_q;
    else if (cmd_i.j_dec)  j_q <= j_q - AddrW'(1);
    if (cmd_i.v_load)      v_q <= rdata_q;
    if (cmd_i.k_init)      k_q <= '0;
    else if (cmd_i.k_inc)  k_q <= k_q + IdxW'(1);
  end

  // position p*n - 1/2 in signed Q13.16
  assign p_sat   = (prob_q[k_q] > ProbOne) ? ProbOne : prob_q[k_q];
  assign pn      = MulW'(p_sat) * MulW'(n_q);
  assign lo_full = pos_q[PosW-2:FracW];
  assign frac    = pos_q[FracW-1:0];
  assign hi_full = lo_full + PosIntW'(frac != '0);
  assign nm1_ext = PosIntW'(nm1);

  // interpolation pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_load) pos_q <= {1'b0, pn} - HalfQ16;
    if (cmd_i.idx_load) begin
      if (pos_q[PosW-1]) begin
        lo_q   <= '0;
        hi_q   <= '0;
        frac_q <= '0;
      end else begin
        lo_q   <= (lo_full > nm1_ext) ? nm1[AddrW-1:0] : lo_full[AddrW-1:0];
        hi_q   <= (hi_full > nm1_ext) ? nm1[AddrW-1:0] : hi_full[AddrW-1:0];
        frac_q <= frac;
      end
    end
    if (cmd_i.dl_load)   dl_q   <= rdata_q;
    if (cmd_i.prod_load) prod_q <= ResultW'(frac_q) * ResultW'(rdata_q - dl_q);
  end

  // results used this dataset
  always_comb begin
    if (n_q == CntW'(1) || num_probs_q == '0) used_m1 = '0;
    else if (num_probs_q > NumProbW'(NumProbRegs)) used_m1 = IdxW'(NumProbRegs - 1);
    else used_m1 = IdxW'(num_probs_q - NumProbW'(1));
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q      <= {dl_q, {FracW{1'b0}}} + prod_q;
      out_idx_q  <= k_q;
      out_last_q <= (k_q == used_m1);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quantile_value_o = out_q;
  assign prob_index_o     = out_idx_q;
  assign last_result_o    = out_last_q;

  always_comb begin
    sts_o.ds_done     = in_fire & last_i;
    sts_o.n_zero      = (n_q == '0);
    sts_o.n_gt1       = (n_q > CntW'(1));
    sts_o.i_next_lt_n = ((CntW'(i_q) + CntW'(1)) < n_q);
    sts_o.shift_gt    = (rdata_q > v_q);
    sts_o.j_is_one    = (j_q == AddrW'(1));
    sts_o.last_k      = (k_q == used_m1);
    sts_o.out_busy    = out_valid_q & ~out_ready_i;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSamples)) else $error("fill count overflow");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_idx_q < IdxW'(NumProbRegs)) else $error("bad prob index");
  a_lo_le_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_load |=> lo_q <= hi_q) else $error("left above right");

endmodule

`default_nettype wire
